>>> hdl/epc_pkg.sv
// Shared constants, codes and controller/datapath bundles for the ensemble point correlation unit.
package epc_pkg;

	localparam int MAX_FIELDS  = 16;
	localparam int DIM         = 16;
	localparam int NPOINTS     = DIM * DIM * DIM;
	localparam int STORE_DEPTH = MAX_FIELDS * NPOINTS;

	localparam int SAMPLE_W = 32;
	localparam int PT_W     = $clog2(NPOINTS);
	localparam int FLD_W    = $clog2(MAX_FIELDS);
	localparam int ADDR_W   = $clog2(STORE_DEPTH);
	localparam int POS_W    = ADDR_W + 1;
	localparam int NF_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int SUM_W    = SAMPLE_W + FLD_W;
	localparam int DEV_W    = SAMPLE_W + 1;
	localparam int PROD_W   = 2 * DEV_W;
	localparam int SQ_W     = 2 * DEV_W + FLD_W - 1;
	localparam int SXY_W    = SQ_W + 1;
	localparam int CORR_W   = 18;

	// divider / root unit widths
	localparam int DIV_W      = 64;
	localparam int DIV_Q_W    = 32;
	localparam int STEP_W     = 6;
	localparam int FRAC_BITS  = 17;
	localparam int CORR_LEAD  = 4;
	localparam int ROOT_W     = 31;
	localparam int HALF_W     = 7;
	localparam logic [STEP_W-1:0] STEPS_FULL = STEP_W'(DIV_Q_W);
	localparam logic [STEP_W-1:0] STEPS_CORR = STEP_W'(FRAC_BITS + CORR_LEAD);
	localparam logic [16:0] CORR_ONE = 17'd65536;

	// command operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FIELDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_INDEX  = 2'd1;

	localparam logic [NF_W-1:0] NUM_FIELDS_RST = 5'd16;
	localparam logic [PT_W-1:0] REF_INDEX_RST  = 12'd2184;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOT_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO_VAR = 2'd2;

	typedef enum logic [1:0] {
		DIV_MEAN_X = 2'd0,
		DIV_MEAN_Y = 2'd1,
		DIV_VAR    = 2'd2,
		DIV_CORR   = 2'd3
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_XX = 2'd0,
		MUL_YY = 2'd1,
		MUL_XY = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     q_start;
		logic     res_notfull;
		logic     addr_y;
		logic     acc_sx;
		logic     acc_sy;
		logic     fld_inc;
		logic     fld_clr;
		logic     div_go;
		div_sel_t div_sel;
		logic     cap_mx;
		logic     cap_my;
		logic     cap_dx;
		logic     cap_dy;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_xx;
		logic     acc_yy;
		logic     acc_xy;
		logic     cap_var;
		logic     root_go;
		logic     root_sel;
		logic     cap_rx;
		logic     cap_ry;
		logic     mul_d;
		logic     cap_corr;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fld_last;
		logic div_busy;
		logic root_busy;
		logic zero_var;
	} sts_t;

endpackage

>>> hdl/epc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module epc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/epc_div.sv
// Restoring divider, one quotient bit per cycle.
module epc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             go,
	input  logic [epc_pkg::DIV_W-1:0]        rem0,
	input  logic [epc_pkg::DIV_Q_W-1:0]      low,
	input  logic [epc_pkg::DIV_W-1:0]        divisor,
	input  logic [epc_pkg::STEP_W-1:0]       steps,
	output logic                             busy,
	output logic [epc_pkg::DIV_Q_W-1:0]      quo,
	output logic [epc_pkg::DIV_W-1:0]        rem
);

	logic [epc_pkg::DIV_W-1:0]   rem_q;
	logic [epc_pkg::DIV_W-1:0]   dvs_q;
	logic [epc_pkg::DIV_Q_W-1:0] low_q;
	logic [epc_pkg::DIV_Q_W-1:0] quo_q;
	logic [epc_pkg::STEP_W-1:0]  cnt_q;
	logic                        busy_q;
	logic [epc_pkg::DIV_W-1:0]   trial;
	logic                        ge;

	assign trial = {rem_q[epc_pkg::DIV_W-2:0], low_q[epc_pkg::DIV_Q_W-1]};
	assign ge    = (trial >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == epc_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= rem0;
			low_q <= low;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - dvs_q) : trial;
			low_q <= {low_q[epc_pkg::DIV_Q_W-2:0], 1'b0};
			quo_q <= {quo_q[epc_pkg::DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> hdl/epc_root.sv
// Normalizing integer square root: even shift into [2^60, 2^62), then two bits per cycle.
module epc_root (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [epc_pkg::SQ_W-1:0]          s,
	output logic                              busy,
	output logic [epc_pkg::ROOT_W-1:0]        root,
	output logic signed [epc_pkg::HALF_W-1:0] half
);

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_NORM = 3'b010,
		R_ROOT = 3'b100
	} root_state_t;

	root_state_t state_q;
	logic [epc_pkg::SQ_W-1:0]          s_q;
	logic signed [epc_pkg::HALF_W-1:0] half_q;
	logic [63:0]                       x_q;
	logic [63:0]                       r_q;
	logic [63:0]                       bit_q;
	logic [63:0]                       t;
	logic                              too_big;
	logic                              too_small;

	assign too_big   = |s_q[epc_pkg::SQ_W-1:62];
	assign too_small = ~|s_q[61:60];
	assign t         = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			unique case (state_q)
				R_IDLE: if (go) state_q <= R_NORM;
				R_NORM: if (!too_big && !too_small) state_q <= R_ROOT;
				R_ROOT: if (bit_q[0]) state_q <= R_IDLE;
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go && state_q == R_IDLE) begin
			s_q    <= s;
			half_q <= '0;
		end else if (state_q == R_NORM) begin
			if (too_big) begin
				// right shift drops bits
				s_q    <= s_q >> 2;
				half_q <= half_q - 1'b1;
			end else if (too_small) begin
				s_q    <= s_q << 2;
				half_q <= half_q + 1'b1;
			end else begin
				x_q   <= {2'b0, s_q[61:0]};
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
		end else if (state_q == R_ROOT) begin
			if (x_q >= t) begin
				x_q <= x_q - t;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = (state_q != R_IDLE);
	assign root = r_q[epc_pkg::ROOT_W-1:0];
	assign half = half_q;

endmodule

>>> hdl/epc_ctrl.sv
// Command sequencer: loads, and for queries sums, means, deviation products, variance, roots, correlation.
module epc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          operation,
	input  epc_pkg::sts_t sts,
	output epc_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [24:0] {
		S_IDLE = 25'b1 << 0,
		S_SUMX = 25'b1 << 1,
		S_SUMY = 25'b1 << 2,
		S_SUMA = 25'b1 << 3,
		S_MXGO = 25'b1 << 4,
		S_MXW  = 25'b1 << 5,
		S_MYGO = 25'b1 << 6,
		S_MYW  = 25'b1 << 7,
		S_DRX  = 25'b1 << 8,
		S_DRY  = 25'b1 << 9,
		S_DCAP = 25'b1 << 10,
		S_MXX  = 25'b1 << 11,
		S_MYY  = 25'b1 << 12,
		S_MXY  = 25'b1 << 13,
		S_MACC = 25'b1 << 14,
		S_VGO  = 25'b1 << 15,
		S_VW   = 25'b1 << 16,
		S_RXGO = 25'b1 << 17,
		S_RXW  = 25'b1 << 18,
		S_RYGO = 25'b1 << 19,
		S_RYW  = 25'b1 << 20,
		S_MULD = 25'b1 << 21,
		S_CGO  = 25'b1 << 22,
		S_CW   = 25'b1 << 23,
		S_OUT  = 25'b1 << 24
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (operation == epc_pkg::OP_LOAD) begin
						cmd.load = 1'b1;
					end else if (!sts.full) begin
						cmd.res_notfull = 1'b1;
						state_d = S_OUT;
					end else begin
						cmd.q_start = 1'b1;
						state_d = S_SUMX;
					end
				end
			end
			S_SUMX: state_d = S_SUMY;
			S_SUMY: begin
				cmd.addr_y = 1'b1;
				cmd.acc_sx = 1'b1;
				state_d = S_SUMA;
			end
			S_SUMA: begin
				cmd.acc_sy = 1'b1;
				if (sts.fld_last) begin
					state_d = S_MXGO;
				end else begin
					cmd.fld_inc = 1'b1;
					state_d = S_SUMX;
				end
			end
			S_MXGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = epc_pkg::DIV_MEAN_X;
				state_d = S_MXW;
			end
			S_MXW: begin
				cmd.div_sel = epc_pkg::DIV_MEAN_X;
				if (!sts.div_busy) begin
					cmd.cap_mx = 1'b1;
					state_d = S_MYGO;
				end
			end
			S_MYGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = epc_pkg::DIV_MEAN_Y;
				state_d = S_MYW;
			end
			S_MYW: begin
				cmd.div_sel = epc_pkg::DIV_MEAN_Y;
				if (!sts.div_busy) begin
					cmd.cap_my  = 1'b1;
					cmd.fld_clr = 1'b1;
					state_d = S_DRX;
				end
			end
			S_DRX: state_d = S_DRY;
			S_DRY: begin
				cmd.addr_y = 1'b1;
				cmd.cap_dx = 1'b1;
				state_d = S_DCAP;
			end
			S_DCAP: begin
				cmd.cap_dy = 1'b1;
				state_d = S_MXX;
			end
			S_MXX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = epc_pkg::MUL_XX;
				state_d = S_MYY;
			end
			S_MYY: begin
				cmd.acc_xx  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = epc_pkg::MUL_YY;
				state_d = S_MXY;
			end
			S_MXY: begin
				cmd.acc_yy  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = epc_pkg::MUL_XY;
				state_d = S_MACC;
			end
			S_MACC: begin
				cmd.acc_xy = 1'b1;
				if (sts.fld_last) begin
					state_d = S_VGO;
				end else begin
					cmd.fld_inc = 1'b1;
					state_d = S_DRX;
				end
			end
			S_VGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = epc_pkg::DIV_VAR;
				state_d = S_VW;
			end
			S_VW: begin
				cmd.div_sel = epc_pkg::DIV_VAR;
				if (!sts.div_busy) begin
					cmd.cap_var = 1'b1;
					state_d = sts.zero_var ? S_OUT : S_RXGO;
				end
			end
			S_RXGO: begin
				cmd.root_go = 1'b1;
				state_d = S_RXW;
			end
			S_RXW: begin
				if (!sts.root_busy) begin
					cmd.cap_rx = 1'b1;
					state_d = S_RYGO;
				end
			end
			S_RYGO: begin
				cmd.root_go  = 1'b1;
				cmd.root_sel = 1'b1;
				state_d = S_RYW;
			end
			S_RYW: begin
				if (!sts.root_busy) begin
					cmd.cap_ry = 1'b1;
					state_d = S_MULD;
				end
			end
			S_MULD: begin
				cmd.mul_d = 1'b1;
				state_d = S_CGO;
			end
			S_CGO: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = epc_pkg::DIV_CORR;
				state_d = S_CW;
			end
			S_CW: begin
				cmd.div_sel = epc_pkg::DIV_CORR;
				if (!sts.div_busy) begin
					cmd.cap_corr = 1'b1;
					state_d = S_OUT;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

>>> hdl/epc_dp.sv
// Datapath: sample store, configuration, accumulators, divider and root units, result registers.
module epc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  epc_pkg::cmd_t                        cmd,
	output epc_pkg::sts_t                        sts,
	input  logic signed [epc_pkg::SAMPLE_W-1:0]  sample,
	input  logic [epc_pkg::PT_W-1:0]             point,
	input  logic                                 cfg_we,
	input  logic [epc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [epc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic signed [epc_pkg::SAMPLE_W-1:0]  mean,
	output logic [epc_pkg::SAMPLE_W-1:0]         variance,
	output logic signed [epc_pkg::CORR_W-1:0]    correlation,
	output logic [1:0]                           status
);

	localparam int SW = epc_pkg::SAMPLE_W;

	// configuration and load state
	logic [epc_pkg::NF_W-1:0]  nf_q;
	logic [epc_pkg::PT_W-1:0]  ref_q;
	logic [epc_pkg::POS_W-1:0] pos_q;
	logic                      full_q;
	logic [epc_pkg::NF_W-1:0]  n_eff;
	logic [epc_pkg::POS_W-1:0] pos_next;
	logic [epc_pkg::POS_W-1:0] limit;

	// query state
	logic [epc_pkg::PT_W-1:0]  pt_q;
	logic [epc_pkg::FLD_W-1:0] fld_q;
	logic [epc_pkg::ADDR_W-1:0] raddr;
	logic [SW-1:0]             rdata;

	logic signed [epc_pkg::SUM_W-1:0] sum_x_q;
	logic signed [epc_pkg::SUM_W-1:0] sum_y_q;
	logic signed [SW-1:0]             mx_q;
	logic signed [SW-1:0]             my_q;
	logic signed [epc_pkg::DEV_W-1:0] dx_q;
	logic signed [epc_pkg::DEV_W-1:0] dy_q;
	logic signed [epc_pkg::DEV_W-1:0] ma;
	logic signed [epc_pkg::DEV_W-1:0] mb;
	logic signed [epc_pkg::PROD_W-1:0] prod;
	logic signed [epc_pkg::PROD_W-1:0] prod_q;
	logic [epc_pkg::SQ_W-1:0]          sxx_q;
	logic [epc_pkg::SQ_W-1:0]          syy_q;
	logic signed [epc_pkg::SXY_W-1:0]  sxy_q;

	// mean rounding
	logic signed [epc_pkg::SUM_W:0] tsel;
	logic                           tneg;
	logic [epc_pkg::SUM_W:0]        tmag;
	logic [SW:0]                    mq;
	logic [SW:0]                    mean_val;

	// divider
	logic [epc_pkg::DIV_W-1:0]   div_rem0;
	logic [epc_pkg::DIV_Q_W-1:0] div_low;
	logic [epc_pkg::DIV_W-1:0]   div_dvs;
	logic [epc_pkg::STEP_W-1:0]  div_steps;
	logic                        div_busy;
	logic [epc_pkg::DIV_Q_W-1:0] div_quo;
	logic [epc_pkg::DIV_W-1:0]   div_rem;

	// variance
	logic       var_sat;
	logic       var_rnd;
	logic [SW:0] var_q1;

	// roots and correlation
	logic                              root_busy;
	logic [epc_pkg::ROOT_W-1:0]        root_out;
	logic signed [epc_pkg::HALF_W-1:0] root_half;
	logic [epc_pkg::ROOT_W-1:0]        rx_q;
	logic [epc_pkg::ROOT_W-1:0]        ry_q;
	logic signed [epc_pkg::HALF_W-1:0] hx_q;
	logic signed [epc_pkg::HALF_W-1:0] hy_q;
	logic [2*epc_pkg::ROOT_W-1:0]      d_q;
	logic signed [epc_pkg::HALF_W:0]   amt;
	logic signed [epc_pkg::HALF_W:0]   namt;
	logic [epc_pkg::SXY_W-1:0]         mag;
	logic [127:0]                      wide;
	logic [127:0]                      shw;
	logic [63:0]                       sh_lo_q;
	logic                              sh_hi_q;
	logic                              neg_q;
	logic [21:0]                       vr1;
	logic [20:0]                       vr;
	logic [16:0]                       cmag;
	logic [epc_pkg::CORR_W-1:0]        cval;

	// results
	logic signed [SW-1:0]              mean_q;
	logic [SW-1:0]                     var_q;
	logic signed [epc_pkg::CORR_W-1:0] corr_q;
	logic [1:0]                        status_q;

	assign n_eff = (nf_q == '0) ? epc_pkg::NF_W'(1) :
		(nf_q > epc_pkg::NF_W'(epc_pkg::MAX_FIELDS)) ? epc_pkg::NF_W'(epc_pkg::MAX_FIELDS) : nf_q;
	assign limit    = {n_eff, {epc_pkg::PT_W{1'b0}}};
	assign pos_next = pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q   <= epc_pkg::NUM_FIELDS_RST;
			ref_q  <= epc_pkg::REF_INDEX_RST;
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				epc_pkg::REG_NUM_FIELDS: begin
					nf_q   <= cfg_data[epc_pkg::NF_W-1:0];
					pos_q  <= '0;
					full_q <= 1'b0;
				end
				epc_pkg::REG_REF_INDEX: ref_q <= cfg_data[epc_pkg::PT_W-1:0];
				default: ;
			endcase
		end else if (cmd.load) begin
			if (pos_next == limit) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fld_q <= '0;
		end else if (cmd.q_start || cmd.fld_clr) begin
			fld_q <= '0;
		end else if (cmd.fld_inc) begin
			fld_q <= fld_q + 1'b1;
		end
	end

	assign raddr = {fld_q, cmd.addr_y ? ref_q : pt_q};

	epc_ram #(
		.WIDTH(SW),
		.DEPTH(epc_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(pos_q[epc_pkg::ADDR_W-1:0]),
		.wdata(sample),
		.raddr(raddr),
		.rdata(rdata)
	);

	// mean = floor((S + floor(N/2)) / N), same as round half up of S/N
	assign tsel = (cmd.div_sel == epc_pkg::DIV_MEAN_Y) ?
		({sum_y_q[epc_pkg::SUM_W-1], sum_y_q} + (epc_pkg::SUM_W+1)'(n_eff >> 1)) :
		({sum_x_q[epc_pkg::SUM_W-1], sum_x_q} + (epc_pkg::SUM_W+1)'(n_eff >> 1));
	assign tneg = tsel[epc_pkg::SUM_W];
	assign tmag = tneg ? -tsel : tsel;
	assign mq   = {1'b0, div_quo} + (SW+1)'(div_rem != '0);
	assign mean_val = tneg ? -mq : {1'b0, div_quo};

	always_comb begin
		case (cmd.div_sel)
			epc_pkg::DIV_MEAN_X, epc_pkg::DIV_MEAN_Y: begin
				div_rem0  = epc_pkg::DIV_W'(tmag[epc_pkg::SUM_W:SW]);
				div_low   = tmag[SW-1:0];
				div_dvs   = epc_pkg::DIV_W'(n_eff);
				div_steps = epc_pkg::STEPS_FULL;
			end
			epc_pkg::DIV_VAR: begin
				div_rem0  = epc_pkg::DIV_W'(sxx_q[epc_pkg::SQ_W-1:SW]);
				div_low   = sxx_q[SW-1:0];
				div_dvs   = epc_pkg::DIV_W'({n_eff, 16'b0});
				div_steps = epc_pkg::STEPS_FULL;
			end
			default: begin
				div_rem0  = epc_pkg::DIV_W'(sh_lo_q[63:epc_pkg::CORR_LEAD]);
				div_low   = {sh_lo_q[epc_pkg::CORR_LEAD-1:0],
					{(epc_pkg::DIV_Q_W-epc_pkg::CORR_LEAD){1'b0}}};
				div_dvs   = epc_pkg::DIV_W'(d_q);
				div_steps = epc_pkg::STEPS_CORR;
			end
		endcase
	end

	epc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.div_go),
		.rem0   (div_rem0),
		.low    (div_low),
		.divisor(div_dvs),
		.steps  (div_steps),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	epc_root u_root (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (cmd.root_go),
		.s     (cmd.root_sel ? syy_q : sxx_q),
		.busy  (root_busy),
		.root  (root_out),
		.half  (root_half)
	);

	always_comb begin
		case (cmd.mul_sel)
			epc_pkg::MUL_XX: begin
				ma = dx_q;
				mb = dx_q;
			end
			epc_pkg::MUL_YY: begin
				ma = dy_q;
				mb = dy_q;
			end
			default: begin
				ma = dx_q;
				mb = dy_q;
			end
		endcase
	end
	assign prod = ma * mb;

	// variance: saturate when the quotient would not fit 32 bits
	assign var_sat = (sxx_q[epc_pkg::SQ_W-1:48] >= (epc_pkg::SQ_W-48)'(n_eff));
	assign var_rnd = ({div_rem[20:0], 1'b0} >= {1'b0, n_eff, 16'b0});
	assign var_q1  = {1'b0, div_quo} + (SW+1)'(var_rnd);

	// correlation scaling
	assign amt  = (epc_pkg::HALF_W+1)'(hx_q) + (epc_pkg::HALF_W+1)'(hy_q);
	assign namt = -amt;
	assign mag  = sxy_q[epc_pkg::SXY_W-1] ? epc_pkg::SXY_W'(-sxy_q) : epc_pkg::SXY_W'(sxy_q);
	assign wide = 128'(mag);
	assign shw  = amt[epc_pkg::HALF_W] ? (wide >> namt[epc_pkg::HALF_W-1:0]) :
		(wide << amt[epc_pkg::HALF_W-1:0]);

	assign vr1  = {1'b0, div_quo[20:0]} + 22'd1;
	assign vr   = vr1[21:1];
	assign cmag = (sh_hi_q || vr > 21'(epc_pkg::CORR_ONE)) ? epc_pkg::CORR_ONE : vr[16:0];
	assign cval = neg_q ? -{1'b0, cmag} : {1'b0, cmag};

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			pt_q    <= point;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sxx_q   <= '0;
			syy_q   <= '0;
			sxy_q   <= '0;
		end
		if (cmd.acc_sx) sum_x_q <= sum_x_q + epc_pkg::SUM_W'(signed'(rdata));
		if (cmd.acc_sy) sum_y_q <= sum_y_q + epc_pkg::SUM_W'(signed'(rdata));
		if (cmd.cap_mx) mx_q <= mean_val[SW-1:0];
		if (cmd.cap_my) my_q <= mean_val[SW-1:0];
		if (cmd.cap_dx) dx_q <= {rdata[SW-1], rdata} - {mx_q[SW-1], mx_q};
		if (cmd.cap_dy) dy_q <= {rdata[SW-1], rdata} - {my_q[SW-1], my_q};
		if (cmd.mul_en) prod_q <= prod;
		if (cmd.acc_xx) sxx_q <= sxx_q + {{(epc_pkg::SQ_W-epc_pkg::PROD_W){1'b0}}, prod_q};
		if (cmd.acc_yy) syy_q <= syy_q + {{(epc_pkg::SQ_W-epc_pkg::PROD_W){1'b0}}, prod_q};
		if (cmd.acc_xy) begin
			sxy_q <= sxy_q + {{(epc_pkg::SXY_W-epc_pkg::PROD_W){prod_q[epc_pkg::PROD_W-1]}}, prod_q};
		end
		if (cmd.cap_rx) begin
			rx_q <= root_out;
			hx_q <= root_half;
		end
		if (cmd.cap_ry) begin
			ry_q <= root_out;
			hy_q <= root_half;
		end
		if (cmd.mul_d) begin
			d_q     <= rx_q * ry_q;
			sh_lo_q <= shw[63:0];
			sh_hi_q <= |shw[127:64];
			neg_q   <= sxy_q[epc_pkg::SXY_W-1];
		end
		if (cmd.res_notfull) begin
			mean_q   <= '0;
			var_q    <= '0;
			corr_q   <= '0;
			status_q <= epc_pkg::ST_NOT_FULL;
		end
		if (cmd.cap_var) begin
			mean_q   <= mx_q;
			var_q    <= (var_sat || var_q1[SW]) ? {SW{1'b1}} : var_q1[SW-1:0];
			corr_q   <= '0;
			status_q <= (sxx_q == '0 || syy_q == '0) ? epc_pkg::ST_ZERO_VAR : epc_pkg::ST_OK;
		end
		if (cmd.cap_corr) corr_q <= cval;
	end

	assign sts.full      = full_q;
	assign sts.fld_last  = ({1'b0, fld_q} == (n_eff - 1'b1));
	assign sts.div_busy  = div_busy;
	assign sts.root_busy = root_busy;
	assign sts.zero_var  = (sxx_q == '0) || (syy_q == '0);

	assign mean        = mean_q;
	assign variance    = var_q;
	assign correlation = corr_q;
	assign status      = status_q;

endmodule

>>> hdl/ensemble_point_correlation_unit.sv
// Top level of the ensemble point correlation unit.
// Usage:
//   Command channel: a word is taken when start is high and busy is low.
//   operation 0 stores sample as the next entry of the ensemble (field by
//   field, point by point); busy stays low, so loads go back
//   to back. operation 1 asks for mean, variance and correlation of point
//   against the reference point; busy is high until the answer is out.
//   Result channel: done is high for exactly one cycle with mean, variance,
//   correlation and status; the receiver cannot stall it. Loads give none.
//   A query before the store is full answers in the cycle after accept.
//   A full query's time is set by the single store read port (read per
//   field for the sums and again for the products) and multiplier, the
//   bit-serial divider (each mean, the variance and the correlation) and
//   the two-bits-per-cycle square root, run twice after normalization.
//   A zero-variance answer skips the roots.
//   Configuration port: cfg_valid/cfg_ready with cfg_index and cfg_data,
//   always ready; write only while idle. Writing num_fields restarts loads.
//   Reset clears load position and full flag and sets num_fields 16 and
//   ref_index 2184; store contents are undefined until loaded.
module ensemble_point_correlation_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic signed [epc_pkg::SAMPLE_W-1:0]  sample,
	input  logic [epc_pkg::PT_W-1:0]             point,
	output logic                                 done,
	output logic signed [epc_pkg::SAMPLE_W-1:0]  mean,
	output logic [epc_pkg::SAMPLE_W-1:0]         variance,
	output logic signed [epc_pkg::CORR_W-1:0]    correlation,
	output logic [1:0]                           status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [epc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [epc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	epc_pkg::cmd_t cmd;
	epc_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	epc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	epc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.sample     (sample),
		.point      (point),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mean       (mean),
		.variance   (variance),
		.correlation(correlation),
		.status     (status)
	);

endmodule

>>> bench/tb_ensemble_point_correlation_unit.sv
// Self-checking testbench for the ensemble point correlation unit: random loads/queries vs. a predictor.
`timescale 1ns / 1ps

module tb_ensemble_point_correlation_unit;

	localparam logic [epc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic                         op;
		logic [epc_pkg::SAMPLE_W-1:0] smp;
		logic [epc_pkg::PT_W-1:0]     pt;
	} cmd_word_t;

	typedef struct packed {
		logic [epc_pkg::SAMPLE_W-1:0] mean_q;
		logic [epc_pkg::SAMPLE_W-1:0] vari_q;
		logic [epc_pkg::CORR_W-1:0]   corr_q;
		logic [1:0]                   st;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic operation = epc_pkg::OP_LOAD;
	logic signed [epc_pkg::SAMPLE_W-1:0] sample = '0;
	logic [epc_pkg::PT_W-1:0] point = '0;
	logic done;
	logic signed [epc_pkg::SAMPLE_W-1:0] mean;
	logic [epc_pkg::SAMPLE_W-1:0] variance;
	logic signed [epc_pkg::CORR_W-1:0] correlation;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [epc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [epc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	ensemble_point_correlation_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .sample(sample), .point(point),
		.done(done), .mean(mean), .variance(variance),
		.correlation(correlation), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted block state
	logic [epc_pkg::SAMPLE_W-1:0] held [epc_pkg::STORE_DEPTH];
	int unsigned load_ptr = 0;
	bit store_loaded = 1'b0;
	logic [epc_pkg::NF_W-1:0] nf_reg = epc_pkg::NUM_FIELDS_RST;
	logic [epc_pkg::PT_W-1:0] ref_reg = epc_pkg::REF_INDEX_RST;

	// stimulus side
	logic [epc_pkg::SAMPLE_W-1:0] gen_shadow [epc_pkg::STORE_DEPTH];
	int unsigned gen_ptr = 0;
	int unsigned gen_n = 16;
	int unsigned gen_rp = 2184;
	bit gen_ref_flat = 1'b0;

	cmd_word_t cmd_backlog[$];
	stats_t stats_due[$];
	int unsigned n_pushed = 0;
	int unsigned n_taken = 0;
	int fail_count = 0;
	int idle_cycles = 0;

	function automatic int unsigned field_count(logic [epc_pkg::NF_W-1:0] nf);
		if (nf == 0)
			return 1;
		if (nf > epc_pkg::MAX_FIELDS)
			return epc_pkg::MAX_FIELDS;
		return nf;
	endfunction

	function automatic longint point_mean(int unsigned p, int unsigned n);
		longint s = 0;
		longint num, den, q;
		for (int i = 0; i < n; i++)
			s += longint'($signed(held[i * epc_pkg::NPOINTS + p]));
		num = 2 * s + n;
		den = 2 * n;
		q = num / den;
		if (num % den != 0 && num < 0)
			q -= 1;
		return q;
	endfunction

	function automatic int bit_length(logic [127:0] v);
		for (int i = 127; i >= 0; i--)
			if (v[i])
				return i + 1;
		return 0;
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] x);
		logic [63:0] r = 0;
		logic [63:0] t;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// root of s normalized into [2^60, 2^62) by an even shift 2*half
	function automatic logic [63:0] scaled_root(logic [127:0] s, output int half);
		int ex;
		logic [127:0] sh;
		ex = 62 - bit_length(s);
		if (ex % 2 != 0)
			ex -= 1;
		half = ex / 2;
		sh = (ex >= 0) ? (s << ex) : (s >> (-ex));
		return floor_root(sh[63:0]);
	endfunction

	function automatic logic [epc_pkg::CORR_W-1:0] correlation_q16(logic [127:0] sxx,
			logic [127:0] syy, logic [127:0] mag, bit neg);
		int hx, hy, k;
		logic [63:0] rx, ry, d, a;
		logic [127:0] sh, v;
		int c;
		rx = scaled_root(sxx, hx);
		ry = scaled_root(syy, hy);
		d = rx * ry;
		k = hx + hy;
		sh = (k >= 0) ? (mag << k) : (mag >> (-k));
		if (sh[127:64] != 0) begin
			c = 65536;
		end else begin
			a = sh[63:0];
			if (a / d >= 2) begin
				c = 65536;
			end else begin
				v = ({64'd0, a} << epc_pkg::FRAC_BITS) / {64'd0, d};
				v = (v + 1) >> 1;
				c = (v > 65536) ? 65536 : int'(v);
			end
		end
		return neg ? epc_pkg::CORR_W'(-c) : epc_pkg::CORR_W'(c);
	endfunction

	function automatic stats_t query_stats(logic [epc_pkg::PT_W-1:0] pt);
		stats_t r;
		int unsigned n, rp;
		longint mx, my, x, y;
		logic [127:0] ax, ay, sxx, syy, pos, negs, prod, dv, q, rem;
		r = '0;
		if (!store_loaded) begin
			r.st = epc_pkg::ST_NOT_FULL;
			return r;
		end
		n = field_count(nf_reg);
		rp = ref_reg;
		mx = point_mean(pt, n);
		my = point_mean(rp, n);
		sxx = 0; syy = 0; pos = 0; negs = 0;
		for (int i = 0; i < n; i++) begin
			x = longint'($signed(held[i * epc_pkg::NPOINTS + pt])) - mx;
			y = longint'($signed(held[i * epc_pkg::NPOINTS + rp])) - my;
			ax = 128'(x < 0 ? -x : x);
			ay = 128'(y < 0 ? -y : y);
			sxx += ax * ax;
			syy += ay * ay;
			prod = ax * ay;
			if (prod != 0 && ((x < 0) != (y < 0)))
				negs += prod;
			else
				pos += prod;
		end
		dv = 128'(n) << 16;
		q = sxx / dv;
		rem = sxx % dv;
		if (rem * 2 >= dv)
			q += 1;
		if (q > 128'hFFFF_FFFF)
			q = 128'hFFFF_FFFF;
		r.mean_q = epc_pkg::SAMPLE_W'(mx);
		r.vari_q = q[31:0];
		if (sxx == 0 || syy == 0) begin
			r.st = epc_pkg::ST_ZERO_VAR;
		end else begin
			r.st = epc_pkg::ST_OK;
			if (negs > pos)
				r.corr_q = correlation_q16(sxx, syy, negs - pos, 1'b1);
			else
				r.corr_q = correlation_q16(sxx, syy, pos - negs, 1'b0);
		end
		return r;
	endfunction

	function automatic void store_sample(logic [epc_pkg::SAMPLE_W-1:0] v);
		int unsigned lim;
		lim = field_count(nf_reg) * epc_pkg::NPOINTS;
		if (load_ptr >= lim)
			load_ptr = 0;
		held[load_ptr % epc_pkg::STORE_DEPTH] = v;
		load_ptr++;
		if (load_ptr >= lim) begin
			store_loaded = 1'b1;
			load_ptr = 0;
		end
	endfunction

	function automatic int pick_gap(logic op, ref int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm_left = $urandom_range(20, 200);
		if (op == epc_pkg::OP_LOAD) begin
			if (r < 85) return 0;
			if (r < 97) return $urandom_range(1, 3);
			return $urandom_range(5, 40);
		end
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// driver: presents backlog words, applies each accepted word to the predictor
	cmd_word_t cur_word;
	int gap_left = 0;
	int calm_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
		end else begin
			if (start && !busy) begin
				if (cur_word.op == epc_pkg::OP_QUERY)
					stats_due.push_back(query_stats(cur_word.pt));
				else
					store_sample(cur_word.smp);
				n_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cur_word = cmd_backlog.pop_front();
					operation <= cur_word.op;
					sample <= cur_word.smp;
					point <= cur_word.pt;
					start <= 1'b1;
					gap_left = pick_gap(cur_word.op, calm_left);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	stats_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (stats_due.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = stats_due.pop_front();
				if (mean !== want.mean_q) begin
					$error("mean expected %h actual %h", want.mean_q, mean);
					fail_count++;
				end
				if (variance !== want.vari_q) begin
					$error("variance expected %h actual %h", want.vari_q, variance);
					fail_count++;
				end
				if (correlation !== want.corr_q) begin
					$error("correlation expected %h actual %h", want.corr_q, correlation);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status expected %0d actual %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_ensemble_point_correlation_unit: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_word(logic op, logic [epc_pkg::SAMPLE_W-1:0] smp,
			logic [epc_pkg::PT_W-1:0] pt);
		cmd_word_t w;
		w.op = op;
		w.smp = smp;
		w.pt = pt;
		cmd_backlog.push_back(w);
		n_pushed++;
	endtask

	function automatic logic [epc_pkg::SAMPLE_W-1:0] random_sample();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r <= 8)
			return epc_pkg::SAMPLE_W'(int'($urandom_range(0, 131071)) - 65536);
		return $urandom();
	endfunction

	// next load in sequence; some point classes are flat across fields or track the reference
	task automatic gen_load();
		int unsigned lim, f, p;
		logic [epc_pkg::SAMPLE_W-1:0] v;
		lim = gen_n * epc_pkg::NPOINTS;
		if (gen_ptr >= lim)
			gen_ptr = 0;
		f = gen_ptr / epc_pkg::NPOINTS;
		p = gen_ptr % epc_pkg::NPOINTS;
		if (f > 0 && (p % 8 == 3 || (gen_ref_flat && p == gen_rp)))
			v = gen_shadow[p];
		else if (p % 8 == 5 && p > gen_rp)
			v = gen_shadow[f * epc_pkg::NPOINTS + gen_rp];
		else if (p % 8 == 6 && p > gen_rp)
			v = -gen_shadow[f * epc_pkg::NPOINTS + gen_rp];
		else
			v = random_sample();
		gen_shadow[gen_ptr] = v;
		push_word(epc_pkg::OP_LOAD, v, '0);
		gen_ptr++;
	endtask

	task automatic gen_query();
		logic [epc_pkg::PT_W-1:0] p;
		case ($urandom_range(0, 7))
			0: p = epc_pkg::PT_W'(gen_rp);
			1: p = epc_pkg::PT_W'($urandom_range(0, 511) * 8 + 3);
			2: p = epc_pkg::PT_W'($urandom_range(0, 511) * 8 + 5);
			3: p = epc_pkg::PT_W'($urandom_range(0, 511) * 8 + 6);
			default: p = epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1));
		endcase
		push_word(epc_pkg::OP_QUERY, $urandom(), p);
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (n_taken != n_pushed || busy || stats_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(logic [epc_pkg::CFG_IDX_W-1:0] idx,
			logic [epc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		if (idx == epc_pkg::REG_NUM_FIELDS) begin
			nf_reg = data[epc_pkg::NF_W-1:0];
			load_ptr = 0;
			store_loaded = 1'b0;
		end else if (idx == epc_pkg::REG_REF_INDEX) begin
			ref_reg = data[epc_pkg::PT_W-1:0];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [epc_pkg::NF_W-1:0] nf, logic [epc_pkg::PT_W-1:0] rp,
			bit ref_flat, int nq);
		int unsigned lim;
		wait_idle();
		cfg_write(epc_pkg::REG_NUM_FIELDS, {7'($urandom_range(0, 127)), nf});
		cfg_write(epc_pkg::REG_REF_INDEX, rp);
		gen_n = field_count(nf);
		gen_ptr = 0;
		gen_rp = rp;
		gen_ref_flat = ref_flat;
		lim = gen_n * epc_pkg::NPOINTS;
		gen_query();
		for (int i = 0; i < lim; i++) begin
			gen_load();
			if (i == lim / 2)
				gen_query();
		end
		// corner points and the reference itself
		push_word(epc_pkg::OP_QUERY, '0, '0);
		push_word(epc_pkg::OP_QUERY, '1, '1);
		push_word(epc_pkg::OP_QUERY, '0, rp);
		for (int i = 0; i < nq / 2; i++)
			gen_query();
		// hold the sender until every answer is back
		wait_idle();
		for (int i = 0; i < 300; i++) begin
			gen_load();
			if ($urandom_range(0, 19) == 0)
				gen_query();
		end
		for (int i = 0; i < nq / 2; i++)
			gen_query();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// queries at reset defaults around two loads, store never full
		push_word(epc_pkg::OP_QUERY, '0, '0);
		push_word(epc_pkg::OP_QUERY, '0, '1);
		push_word(epc_pkg::OP_LOAD, 32'h7FFF_FFFF, '0);
		push_word(epc_pkg::OP_LOAD, 32'h8000_0000, '0);
		push_word(epc_pkg::OP_QUERY, '0, 12'd2184);
		wait_idle();
		cfg_write(REG_UNMAPPED, '1);
		run_phase(5'd2, 12'd0, 1'b0, 250);
		run_phase(5'd0, 12'd4095, 1'b0, 150);
		run_phase(5'd31, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b0, 100);
		run_phase(5'd3, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b1, 150);
		run_phase(5'd16, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b0, 100);
		run_phase(5'd5, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b0, 300);
		run_phase(5'd1, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b0, 150);
		run_phase(5'd2, epc_pkg::PT_W'($urandom_range(0, epc_pkg::NPOINTS - 1)), 1'b0, 300);
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_ensemble_point_correlation_unit: clean");
		else
			$display("tb_ensemble_point_correlation_unit: errors");
		$finish;
	end

endmodule

>>> files.f
hdl/epc_pkg.sv
hdl/epc_ram.sv
hdl/epc_div.sv
hdl/epc_root.sv
hdl/epc_ctrl.sv
hdl/epc_dp.sv
hdl/ensemble_point_correlation_unit.sv
bench/tb_ensemble_point_correlation_unit.sv
